FILE: design/i2c_pkg.sv
// Shared types, constants and helper functions for the im2col address generator.
`default_nettype none

package i2c_pkg;

    // Largest legal image edge and batch count.
    localparam int MAX_EDGE  = 4096;
    localparam int MAX_BATCH = 256;

    // Pipelined restoring divider: numerator and remainder widths, one bit per stage.
    localparam int DIV_NW    = 24;
    localparam int DIV_RW    = 14;
    localparam int DIV_STEPS = DIV_NW;

    // Cycles after reset or a register write before derived geometry is stable.
    localparam int SETTLE_CYCLES = 32;
    localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_INPUT_HEIGHT    = 3'd0;
    localparam logic [2:0] REG_INPUT_WIDTH     = 3'd1;
    localparam logic [2:0] REG_CHANNEL_COUNT   = 3'd2;
    localparam logic [2:0] REG_KERNEL_DIMS     = 3'd3;
    localparam logic [2:0] REG_STRIDE_DIMS     = 3'd4;
    localparam logic [2:0] REG_DILATION_DIMS   = 3'd5;
    localparam logic [2:0] REG_PAD_BEFORE_DIMS = 3'd6;
    localparam logic [2:0] REG_PAD_AFTER_DIMS  = 3'd7;

    typedef struct packed {
        logic [7:0]  batch_index;
        logic [11:0] channel_index;
        logic [15:0] tap_index;
        logic [23:0] window_index;
    } in_t;

    typedef struct packed {
        logic [43:0] source_address;
        logic [59:0] dest_address;
        logic        is_padding;
        logic        bad_request;
    } out_t;

    typedef struct packed {
        logic [DIV_RW-1:0] acc;
        logic [DIV_NW-1:0] nq;
        logic [DIV_RW-1:0] den;
    } div_stage_t;

    // One restoring division step: shift in the next numerator bit, subtract if it fits.
    function automatic div_stage_t div_step(div_stage_t s);
        logic [DIV_RW:0] shifted;
        logic [DIV_RW:0] diff;
        div_stage_t      r;
        shifted = {s.acc, s.nq[DIV_NW-1]};
        diff    = shifted - {1'b0, s.den};
        r.den   = s.den;
        if (shifted >= {1'b0, s.den})
        begin
            r.acc = diff[DIV_RW-1:0];
            r.nq  = {s.nq[DIV_NW-2:0], 1'b1};
        end
        else
        begin
            r.acc = shifted[DIV_RW-1:0];
            r.nq  = {s.nq[DIV_NW-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [7:0] one_if_zero(logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

`default_nettype wire

FILE: design/i2c_div.sv
// Pipelined restoring divider producing one quotient bit per register stage.
`default_nettype none

module i2c_div (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [i2c_pkg::DIV_NW-1:0] numer,
    input  wire logic [i2c_pkg::DIV_RW-1:0] denom,
    output logic      [i2c_pkg::DIV_NW-1:0] quot,
    output logic      [i2c_pkg::DIV_RW-1:0] rem
);
    import i2c_pkg::*;

    div_stage_t stage_reg  [DIV_STEPS];
    div_stage_t stage_next [DIV_STEPS];
    div_stage_t first;

    always_comb
    begin
        first.acc     = '0;
        first.nq      = numer;
        first.den     = denom;
        stage_next[0] = div_step(first);
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            stage_next[k] = div_step(stage_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign quot = stage_reg[DIV_STEPS-1].nq;
    assign rem  = stage_reg[DIV_STEPS-1].acc;

endmodule

`default_nettype wire

FILE: design/im2col_address_generator.sv
// Top level of the im2col address generator: configuration, geometry and address pipeline.
// Stages: s1, the divider stages beside their delay line, s26 to s29, then the output register.
// Throughput: one transaction per cycle while in_stall is low; stages move when the output moves.
// Reset: registers return to H=W=C=1, 3x3 kernel, unit stride and dilation, no padding.
// After reset and every register write the input stalls until settle_reg counts down, while
// the output grid size is recomputed by the free-running geometry pipeline.
`default_nettype none

module im2col_address_generator (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire i2c_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output i2c_pkg::out_t      out_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_data
);
    import i2c_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always accepted.
    // ------------------------------------------------------------------
    logic [12:0] input_height_reg;
    logic [12:0] input_width_reg;
    logic [12:0] channel_count_reg;
    logic [15:0] kernel_dims_reg;
    logic [15:0] stride_dims_reg;
    logic [15:0] dilation_dims_reg;
    logic [15:0] pad_before_dims_reg;
    logic [15:0] pad_after_dims_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_height_reg    <= 13'd1;
            input_width_reg     <= 13'd1;
            channel_count_reg   <= 13'd1;
            kernel_dims_reg     <= 16'd771;
            stride_dims_reg     <= 16'd257;
            dilation_dims_reg   <= 16'd257;
            pad_before_dims_reg <= 16'd0;
            pad_after_dims_reg  <= 16'd0;
            settle_reg          <= SETTLE_W'(SETTLE_CYCLES);
        end
        else
        begin
            if (cfg_write)
            begin
                settle_reg <= SETTLE_W'(SETTLE_CYCLES);
                unique case (cfg_index)
                    REG_INPUT_HEIGHT:    input_height_reg    <= cfg_data[12:0];
                    REG_INPUT_WIDTH:     input_width_reg     <= cfg_data[12:0];
                    REG_CHANNEL_COUNT:   channel_count_reg   <= cfg_data[12:0];
                    REG_KERNEL_DIMS:     kernel_dims_reg     <= cfg_data;
                    REG_STRIDE_DIMS:     stride_dims_reg     <= cfg_data;
                    REG_DILATION_DIMS:   dilation_dims_reg   <= cfg_data;
                    REG_PAD_BEFORE_DIMS: pad_before_dims_reg <= cfg_data;
                    REG_PAD_AFTER_DIMS:  pad_after_dims_reg  <= cfg_data;
                endcase
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - SETTLE_W'(1);
            end
        end
    end

    // Unpacked register fields; a zero stride or dilation behaves as one.
    logic [12:0] h, w, ch;
    logic [7:0]  kh, kw, sv, sh, dv, dh, pt, pl, pbt, pr;

    assign h   = input_height_reg;
    assign w   = input_width_reg;
    assign ch  = channel_count_reg;
    assign kh  = kernel_dims_reg[15:8];
    assign kw  = kernel_dims_reg[7:0];
    assign sv  = one_if_zero(stride_dims_reg[15:8]);
    assign sh  = one_if_zero(stride_dims_reg[7:0]);
    assign dv  = one_if_zero(dilation_dims_reg[15:8]);
    assign dh  = one_if_zero(dilation_dims_reg[7:0]);
    assign pt  = pad_before_dims_reg[15:8];
    assign pl  = pad_before_dims_reg[7:0];
    assign pbt = pad_after_dims_reg[15:8];
    assign pr  = pad_after_dims_reg[7:0];

    // ------------------------------------------------------------------
    // Geometry pipeline. It runs every cycle from the configuration
    // registers and settles after the last write; the input is held
    // off until then, so every transaction sees settled values.
    // ------------------------------------------------------------------
    logic [15:0] spanm_v_reg, spanm_h_reg;
    logic [13:0] padded_v_reg, padded_h_reg;
    logic        kzero_v_reg, kzero_h_reg;
    logic [DIV_NW-1:0] num_v_reg, num_h_reg;
    logic        empty_v_reg, empty_h_reg;
    logic [DIV_NW-1:0] grid_qv, grid_qh;
    logic [DIV_RW-1:0] grid_rv, grid_rh;
    logic [13:0] oh_reg, ow_reg;
    logic [27:0] windows_reg;
    logic [15:0] taps_reg;
    logic        cfg_bad_reg;

    logic [16:0] span_v, span_h;

    assign span_v = 17'(spanm_v_reg) + 17'd1;
    assign span_h = 17'(spanm_h_reg) + 17'd1;

    always_ff @(posedge clk)
    begin
        // Dilated kernel extent minus one, and the padded image extent.
        spanm_v_reg  <= 16'(dv) * 16'(kh - 8'd1);
        spanm_h_reg  <= 16'(dh) * 16'(kw - 8'd1);
        padded_v_reg <= 14'(h) + 14'(pt) + 14'(pbt);
        padded_h_reg <= 14'(w) + 14'(pl) + 14'(pr);
        kzero_v_reg  <= (kh == 8'd0);
        kzero_h_reg  <= (kw == 8'd0);

        empty_v_reg  <= kzero_v_reg || (17'(padded_v_reg) < span_v);
        empty_h_reg  <= kzero_h_reg || (17'(padded_h_reg) < span_h);
        num_v_reg    <= DIV_NW'(17'(padded_v_reg) - span_v);
        num_h_reg    <= DIV_NW'(17'(padded_h_reg) - span_h);

        oh_reg <= empty_v_reg ? 14'd0 : 14'(grid_qv) + 14'd1;
        ow_reg <= empty_h_reg ? 14'd0 : 14'(grid_qh) + 14'd1;

        windows_reg <= 28'(oh_reg) * 28'(ow_reg);
        taps_reg    <= 16'(kh) * 16'(kw);
        cfg_bad_reg <= (h == 13'd0) || (w == 13'd0) || (ch == 13'd0) ||
                       (32'(h) > MAX_EDGE) || (32'(w) > MAX_EDGE) ||
                       (kh == 8'd0) || (kw == 8'd0) ||
                       (oh_reg == 14'd0) || (ow_reg == 14'd0);
    end

    i2c_div u_grid_div_v (
        .clk   (clk),
        .en    (1'b1),
        .numer (num_v_reg),
        .denom (DIV_RW'(sv)),
        .quot  (grid_qv),
        .rem   (grid_rv)
    );

    i2c_div u_grid_div_h (
        .clk   (clk),
        .en    (1'b1),
        .numer (num_h_reg),
        .denom (DIV_RW'(sh)),
        .quot  (grid_qh),
        .rem   (grid_rh)
    );

    // ------------------------------------------------------------------
    // Address pipeline. All stages move together whenever the output
    // register is empty or its transaction is being taken.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic        bad;
        logic [7:0]  n;
        logic [11:0] c;
        logic [15:0] tap;
        logic [23:0] win;
    } side_t;

    logic advance, accept;

    logic  s1_v_reg;
    side_t s1_reg;
    logic  dly_v_reg [DIV_STEPS];
    side_t dly_reg   [DIV_STEPS];

    logic [DIV_NW-1:0] win_q, tap_q;
    logic [DIV_RW-1:0] win_r, tap_r;

    logic        s26_v_reg, s26_bad_reg;
    logic [32:0] s26_yp_reg;
    logic [22:0] s26_xp_reg;
    logic [21:0] s26_nc_reg;
    logic [15:0] s26_tap_reg;
    logic [23:0] s26_win_reg;

    logic        s27_v_reg, s27_bad_reg, s27_pad_reg;
    logic [12:0] s27_y_reg, s27_x_reg;
    logic [34:0] s27_nch_reg;
    logic [38:0] s27_nct_reg;
    logic [23:0] s27_win_reg;

    logic        s28_v_reg, s28_bad_reg, s28_pad_reg;
    logic [35:0] s28_sy_reg;
    logic [12:0] s28_x_reg;
    logic [38:0] s28_dt_reg;
    logic [23:0] s28_win_reg;

    logic        s29_v_reg, s29_bad_reg, s29_pad_reg;
    logic [43:0] s29_sprod_reg;
    logic [12:0] s29_x_reg;
    logic [47:0] s29_dlo_reg;
    logic [46:0] s29_dhi_reg;
    logic [23:0] s29_win_reg;

    logic  out_valid_reg;
    out_t  out_reg;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = !advance || (settle_reg != '0);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Valid bits travel beside the data and are the only reset state here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dly_v_reg[k] <= 1'b0;
            end
            s26_v_reg     <= 1'b0;
            s27_v_reg     <= 1'b0;
            s28_v_reg     <= 1'b0;
            s29_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_v_reg     <= accept;
            dly_v_reg[0] <= s1_v_reg;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                dly_v_reg[k] <= dly_v_reg[k-1];
            end
            s26_v_reg     <= dly_v_reg[DIV_STEPS-1];
            s27_v_reg     <= s26_v_reg;
            s28_v_reg     <= s27_v_reg;
            s29_v_reg     <= s28_v_reg;
            out_valid_reg <= s29_v_reg;
        end
    end

    // Window and tap indices split into row and column.
    i2c_div u_win_div (
        .clk   (clk),
        .en    (advance),
        .numer (s1_reg.win),
        .denom (ow_reg),
        .quot  (win_q),
        .rem   (win_r)
    );

    i2c_div u_tap_div (
        .clk   (clk),
        .en    (advance),
        .numer (DIV_NW'(s1_reg.tap)),
        .denom (DIV_RW'(kw)),
        .quot  (tap_q),
        .rem   (tap_r)
    );

    // Stage arithmetic.
    side_t       s1_next;
    logic [31:0] yp_row;
    logic [23:0] yp_tap;
    logic [21:0] xp_col;
    logic [15:0] xp_tap;
    logic [21:0] nc_next;
    logic        pad_next;
    logic [32:0] ydiff;
    logic [22:0] xdiff;
    out_t        out_next;

    always_comb
    begin
        s1_next.n   = in_data.batch_index;
        s1_next.c   = in_data.channel_index;
        s1_next.tap = in_data.tap_index;
        s1_next.win = in_data.window_index;
        s1_next.bad = cfg_bad_reg ||
                      (32'(in_data.batch_index) >= MAX_BATCH) ||
                      (13'(in_data.channel_index) >= ch) ||
                      (in_data.tap_index >= taps_reg) ||
                      (28'(in_data.window_index) >= windows_reg);

        // Source position before the leading pad is removed.
        yp_row  = 32'(win_q) * 32'(sv);
        yp_tap  = 24'(tap_q[15:0]) * 24'(dv);
        xp_col  = 22'(win_r) * 22'(sh);
        xp_tap  = 16'(tap_r[7:0]) * 16'(dh);
        nc_next = 22'(dly_reg[DIV_STEPS-1].n) * 22'(ch) + 22'(dly_reg[DIV_STEPS-1].c);

        ydiff    = s26_yp_reg - 33'(pt);
        xdiff    = s26_xp_reg - 23'(pl);
        pad_next = (s26_yp_reg < 33'(pt)) || (ydiff >= 33'(h)) ||
                   (s26_xp_reg < 23'(pl)) || (xdiff >= 23'(w));

        // Final sums; bad requests zero the other fields, padded pixels the source address.
        out_next.bad_request    = s29_bad_reg;
        out_next.is_padding     = !s29_bad_reg && s29_pad_reg;
        out_next.dest_address   = s29_bad_reg ? 60'd0 :
                                  60'(s29_dlo_reg) + 60'({s29_dhi_reg, 20'd0}) +
                                  60'(s29_win_reg);
        out_next.source_address = (s29_bad_reg || s29_pad_reg) ? 44'd0 :
                                  s29_sprod_reg + 44'(s29_x_reg);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg     <= s1_next;
            dly_reg[0] <= s1_reg;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                dly_reg[k] <= dly_reg[k-1];
            end

            s26_bad_reg <= dly_reg[DIV_STEPS-1].bad;
            s26_yp_reg  <= 33'(yp_row) + 33'(yp_tap);
            s26_xp_reg  <= 23'(xp_col) + 23'(xp_tap);
            s26_nc_reg  <= nc_next;
            s26_tap_reg <= dly_reg[DIV_STEPS-1].tap;
            s26_win_reg <= dly_reg[DIV_STEPS-1].win;

            s27_bad_reg <= s26_bad_reg;
            s27_pad_reg <= pad_next;
            s27_y_reg   <= ydiff[12:0];
            s27_x_reg   <= xdiff[12:0];
            s27_nch_reg <= 35'(s26_nc_reg) * 35'(h);
            s27_nct_reg <= 39'(s26_nc_reg) * 39'(taps_reg) + 39'(s26_tap_reg);
            s27_win_reg <= s26_win_reg;

            s28_bad_reg <= s27_bad_reg;
            s28_pad_reg <= s27_pad_reg;
            s28_sy_reg  <= 36'(s27_nch_reg) + 36'(s27_y_reg);
            s28_x_reg   <= s27_x_reg;
            s28_dt_reg  <= s27_nct_reg;
            s28_win_reg <= s27_win_reg;

            // The destination product is split into two partial products.
            s29_bad_reg   <= s28_bad_reg;
            s29_pad_reg   <= s28_pad_reg;
            s29_sprod_reg <= 44'(s28_sy_reg) * 44'(w);
            s29_x_reg     <= s28_x_reg;
            s29_dlo_reg   <= 48'(s28_dt_reg[19:0]) * 48'(windows_reg);
            s29_dhi_reg   <= 47'(s28_dt_reg[38:20]) * 47'(windows_reg);
            s29_win_reg   <= s28_win_reg;

            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

FILE: tb/im2col_checker.sv
// Checker for the im2col address generator: predicts every result and compares it.
module im2col_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_stall,
    input  wire i2c_pkg::in_t  in_data,
    input  wire logic          out_valid,
    input  wire logic          out_stall,
    input  wire i2c_pkg::out_t out_data,
    input  wire logic          cfg_valid,
    input  wire logic          cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    output int                 error_count,
    output int                 pending_count,
    output int                 result_count,
    output int                 padded_count,
    output int                 rejected_count
);
    import i2c_pkg::*;

    logic [12:0] img_h, img_w, chans;
    logic [15:0] kern, strd, dila, padb, pada;
    out_t        address_queue[$];

    function automatic longint unsigned axis_extent(longint unsigned size, longint unsigned pb,
        longint unsigned pa, longint unsigned k, longint unsigned d, longint unsigned s);
        longint unsigned padded, span;
        padded = size + pb + pa;
        span   = d * (k - 1) + 1;
        if (k == 0 || padded < span)
            return 0;
        return (padded - span) / s + 1;
    endfunction

    function automatic longint unsigned nz(logic [7:0] v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic out_t compute_addresses(in_t req);
        out_t r;
        longint unsigned h, w, ch, kh, kw, sv, sh, dv, dh, pt, pl, pbt, pr;
        longint unsigned oh, ow, taps, wins, yp, xp, n, c, tap, win;
        logic bad;
        h = img_h; w = img_w; ch = chans;
        kh = kern[15:8]; kw = kern[7:0];
        sv = nz(strd[15:8]); sh = nz(strd[7:0]);
        dv = nz(dila[15:8]); dh = nz(dila[7:0]);
        pt = padb[15:8]; pl = padb[7:0]; pbt = pada[15:8]; pr = pada[7:0];
        n = req.batch_index; c = req.channel_index;
        tap = req.tap_index; win = req.window_index;
        oh = axis_extent(h, pt, pbt, kh, dv, sv);
        ow = axis_extent(w, pl, pr, kw, dh, sh);
        taps = kh * kw;
        wins = oh * ow;
        bad = h == 0 || w == 0 || ch == 0 || h > MAX_EDGE || w > MAX_EDGE ||
              kh == 0 || kw == 0 || oh == 0 || ow == 0 || n >= MAX_BATCH ||
              c >= ch || tap >= taps || win >= wins;
        r = '0;
        r.bad_request = bad;
        if (!bad)
        begin
            yp = (win / ow) * sv + (tap / kw) * dv;
            xp = (win % ow) * sh + (tap % kw) * dh;
            r.dest_address = (n * ch * taps + c * taps + tap) * wins + win;
            if (yp < pt || yp - pt >= h || xp < pl || xp - pl >= w)
                r.is_padding = 1'b1;
            else
                r.source_address = ((n * ch + c) * h + (yp - pt)) * w + (xp - pl);
        end
        return r;
    endfunction

    assign pending_count = address_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_t exp_r;
        if (!rst_n)
        begin
            img_h <= 1; img_w <= 1; chans <= 1;
            kern <= 16'd771; strd <= 16'd257; dila <= 16'd257;
            padb <= 0; pada <= 0;
            error_count = 0; result_count = 0; padded_count = 0; rejected_count = 0;
            address_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_INPUT_HEIGHT:    img_h <= cfg_data[12:0];
                    REG_INPUT_WIDTH:     img_w <= cfg_data[12:0];
                    REG_CHANNEL_COUNT:   chans <= cfg_data[12:0];
                    REG_KERNEL_DIMS:     kern <= cfg_data;
                    REG_STRIDE_DIMS:     strd <= cfg_data;
                    REG_DILATION_DIMS:   dila <= cfg_data;
                    REG_PAD_BEFORE_DIMS: padb <= cfg_data;
                    default:             pada <= cfg_data;
                endcase
            end
            if (in_valid && !in_stall)
                address_queue.push_back(compute_addresses(in_data));
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (address_queue.size() == 0)
                begin
                    $error("result with no expectation waiting");
                    error_count++;
                end
                else
                begin
                    exp_r = address_queue.pop_front();
                    padded_count += exp_r.is_padding;
                    rejected_count += exp_r.bad_request;
                    if (out_data.source_address !== exp_r.source_address)
                    begin
                        $error("source_address: expected %0h actual %0h",
                               exp_r.source_address, out_data.source_address);
                        error_count++;
                    end
                    if (out_data.dest_address !== exp_r.dest_address)
                    begin
                        $error("dest_address: expected %0h actual %0h",
                               exp_r.dest_address, out_data.dest_address);
                        error_count++;
                    end
                    if (out_data.is_padding !== exp_r.is_padding)
                    begin
                        $error("is_padding: expected %0b actual %0b",
                               exp_r.is_padding, out_data.is_padding);
                        error_count++;
                    end
                    if (out_data.bad_request !== exp_r.bad_request)
                    begin
                        $error("bad_request: expected %0b actual %0b",
                               exp_r.bad_request, out_data.bad_request);
                        error_count++;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/tb_im2col_address_generator.sv
// Testbench top for the im2col address generator: stimulus, configuration phases and verdict.
module tb_im2col_address_generator;
    import i2c_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int error_count, pending_count, result_count, padded_count, rejected_count;

    // Idling control: the stimulus raises calm to switch off random gaps on both
    // sides, and hold_off asks the receiver to stall for a long counted stretch.
    logic calm = 1'b0;
    logic hold_off = 1'b0;
    logic hold_done = 1'b0;
    int   sent_count = 0;

    // Shadow of the geometry, so that requests can be aimed mostly at valid indices.
    int g_c = 1, g_taps = 9, g_wins = 1;

    always #5 clk = ~clk;

    im2col_address_generator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    im2col_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .error_count(error_count), .pending_count(pending_count),
        .result_count(result_count), .padded_count(padded_count),
        .rejected_count(rejected_count)
    );

    // Receiver: random stalls about 29 percent of the time, none while calm, and
    // one long hold-off while the sender keeps offering transactions.
    initial
    begin
        int k;
        forever
        begin
            @(negedge clk);
            if (hold_off && !hold_done)
            begin
                out_stall <= 1'b1;
                for (k = 0; k < 200; k++)
                    @(negedge clk);
                hold_done <= 1'b1;
            end
            out_stall <= !calm && ($urandom_range(99) < 29);
        end
    end

    // Picks a random transaction: mostly valid indices, some out of range and full noise.
    function automatic in_t pick_request();
        in_t r;
        int  mode;
        mode = $urandom_range(99);
        r.batch_index   = 8'($urandom);
        r.channel_index = 12'($urandom_range(g_c - 1));
        r.tap_index     = 16'($urandom_range(g_taps - 1));
        r.window_index  = 24'($urandom_range(g_wins - 1));
        if (mode < 6)
            r = 60'({$urandom, $urandom});
        else if (mode < 9)
            r.channel_index = 12'(g_c + $urandom_range(3));
        else if (mode < 12)
            r.tap_index = 16'(g_taps + $urandom_range(3));
        else if (mode < 15)
            r.window_index = 24'(g_wins + $urandom_range(3));
        return r;
    endfunction

    // Offers one transaction, with a random gap before it, and waits for acceptance.
    task automatic send_request(input in_t req);
        while (!calm && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Presents one register write and waits for it to be taken; the caller lowers
    // cfg_valid once its last write is done, so back-to-back writes stay valid.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic int extent(int size, int pb, int pa, int k, int d, int s);
        if (k == 0 || size + pb + pa < d * (k - 1) + 1)
            return 0;
        return (size + pb + pa - d * (k - 1) - 1) / s + 1;
    endfunction

    // Writes a whole setting and refreshes the geometry shadow.
    task automatic set_geometry(input int h, input int w, input int c, input logic [15:0] kd,
        input logic [15:0] sd, input logic [15:0] dd, input logic [15:0] pbd,
        input logic [15:0] pad);
        int oh, ow;
        write_reg(REG_INPUT_HEIGHT, 16'(h));
        write_reg(REG_INPUT_WIDTH, 16'(w));
        write_reg(REG_CHANNEL_COUNT, 16'(c));
        write_reg(REG_KERNEL_DIMS, kd);
        write_reg(REG_STRIDE_DIMS, sd);
        write_reg(REG_DILATION_DIMS, dd);
        write_reg(REG_PAD_BEFORE_DIMS, pbd);
        write_reg(REG_PAD_AFTER_DIMS, pad);
        cfg_valid <= 1'b0;
        oh = extent(h, pbd[15:8], pad[15:8], kd[15:8],
                    dd[15:8] == 0 ? 1 : dd[15:8], sd[15:8] == 0 ? 1 : sd[15:8]);
        ow = extent(w, pbd[7:0], pad[7:0], kd[7:0],
                    dd[7:0] == 0 ? 1 : dd[7:0], sd[7:0] == 0 ? 1 : sd[7:0]);
        g_c    = (c < 1) ? 1 : (c > 4096 ? 4096 : c);
        g_taps = (kd[15:8] * kd[7:0] < 1) ? 1 : kd[15:8] * kd[7:0];
        g_wins = (oh * ow < 1) ? 1 : (oh * ow > 16777216 ? 16777216 : oh * ow);
    endtask

    task automatic send_random(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_request(pick_request());
    endtask

    initial
    begin
        in_t req;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under reset geometry: 1x1 image, 3x3 kernel, an empty window grid.
        req = '0; req.tap_index = 4; send_request(req);
        req = '0; req.tap_index = 0; send_request(req);
        req = '0; req.tap_index = 9; send_request(req);
        req = '0; req.window_index = 1; send_request(req);
        req = '0; req.channel_index = 1; send_request(req);
        req = '1; send_request(req);
        wait_drained();

        // Padding, zero stride and dilation, and the extremes of every index field.
        set_geometry(8, 8, 4096, 16'h0303, 16'h0000, 16'h0000, 16'h0101, 16'h0101);
        req = '0; send_request(req);
        req.batch_index = 255; req.channel_index = 4095; req.tap_index = 8;
        req.window_index = 63; send_request(req);
        req.tap_index = 4; req.window_index = 27; send_request(req);
        req = '0; req.window_index = 64; send_request(req);
        wait_drained();

        // Largest image and wide kernel features so the source address can reach the top of its width.
        set_geometry(4096, 4096, 4096, 16'hFFFF, 16'hFFFF, 16'h0101, 16'hFFFF, 16'hFFFF);
        req = '1; req.window_index = 0; req.batch_index = 255; req.channel_index = 4095;
        req.tap_index = 65024; send_request(req);
        send_random(8);
        wait_drained();

        // Invalid settings: zero sizes, oversize edge, zero kernel, empty grid.
        set_geometry(0, 4097, 0, 16'h0000, 16'h0101, 16'h0101, 16'h0000, 16'h0000);
        req = '0; send_request(req);
        wait_drained();
        set_geometry(4, 4, 2, 16'h0505, 16'h0101, 16'h0101, 16'h0000, 16'h0000);
        req = '0; send_request(req);
        wait_drained();

        // Random phases over several geometries, one with the long receiver hold-off.
        set_geometry(6, 7, 3, 16'h0302, 16'h0201, 16'h0102, 16'h0102, 16'h0201);
        hold_off <= 1'b1;
        send_random(350);
        wait_drained();
        set_geometry(33, 20, 17, 16'h0505, 16'h0302, 16'h0203, 16'h0203, 16'h0300);
        calm <= 1'b1;
        send_random(250);
        calm <= 1'b0;
        send_random(150);
        wait_drained();
        set_geometry(1, 1, 1, 16'h0101, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_random(200);
        wait_drained();
        set_geometry(100, 257, 4095, 16'h0709, 16'hFF03, 16'h0204, 16'hFF03, 16'h0009);
        send_random(300);
        wait_drained();
        set_geometry(12, 9, 64, 16'h0303, 16'h0102, 16'h0101, 16'h0201, 16'h0102);
        send_random(300);
        wait_drained();

        $display("Covered %0d transactions and %0d results over ten settings.",
                 sent_count, result_count);
        $display("Of those, %0d fell in padding and %0d were rejected.",
                 padded_count, rejected_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
